@@ design/adaptive_antireplay_window_macros.svh @@
// Assertion macros for the anti-replay window checker.
// Used by the checker file only; no other dependencies.
`ifndef ADAPTIVE_ANTIREPLAY_WINDOW_MACROS_SVH
`define ADAPTIVE_ANTIREPLAY_WINDOW_MACROS_SVH

// assert that a condition implies a consequence in the same cycle
`define AAW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// assert that a condition implies a consequence in the next cycle
`define AAW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aaw_pkg.sv @@
// Shared constants and types of the anti-replay window block.
// No dependencies; imported by every design module.
package aaw_pkg;

    localparam int NUM_SOURCES_DEF = 256;
    localparam int WINDOW_BITS_DEF = 64;

    localparam int SRC_W      = 8;
    localparam int SEQ_W      = 32;
    localparam int ARR_W      = 48;
    localparam int AVG_W      = 56;
    localparam int WMSG_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_NUM_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

    localparam logic              EN_RESET  = 1'b1;
    localparam logic [SEQ_W-1:0]  WT_RESET  = 32'd1000000;
    localparam logic [AVG_W-1:0]  AVG_RESET = 56'd256000000;
    localparam logic [AVG_W-1:0]  AVG_DIV   = 56'd10;

    typedef enum logic {
        DIV_AVG = 1'b0,
        DIV_WIN = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     mod_sub;
        logic     rd;
        logic     eval;
        logic     div_start;
        t_div_sel div_sel;
        logic     avg_take;
        logic     win_take;
        logic     seq_wr;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic src_ge;
        logic enable;
        logic upd_avg;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/aaw_divider.sv @@
// Dividers of the anti-replay window block: a restoring divider with one quotient bit
// per cycle, and a divide by ten from a shift-and-add estimate with a remainder fix-up.
// Depends on aaw_pkg.
module aaw_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aaw_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [aaw_pkg::AVG_W-1:0]     i_den,
    output logic                          o_done,
    output logic [aaw_pkg::DIV_NUM_W-1:0] o_quo
);
    import aaw_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W);

    logic                 r_busy, r_done;
    logic [CW-1:0]        r_cnt;
    logic [DIV_NUM_W-1:0] r_nq;
    logic [AVG_W-1:0]     r_rem, r_den;
    logic [AVG_W:0]       rem_sh, rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_nq[DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_nq  <= {r_nq[DIV_NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[AVG_W-1:0] : rem_sh[AVG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq;

endmodule

module aaw_div10 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aaw_pkg::DIV_NUM_W-1:0] i_num,
    output logic                          o_done,
    output logic [aaw_pkg::DIV_NUM_W-1:0] o_quo
);
    import aaw_pkg::*;

    localparam logic [2:0]           STEP_SCALE = 3'd4;
    localparam logic [2:0]           STEP_REM   = 3'd5;
    localparam logic [2:0]           STEP_FIX   = 3'd6;
    localparam logic [DIV_NUM_W-1:0] DIVISOR    = 64'd10;

    logic                 r_busy, r_done;
    logic [2:0]           r_cnt;
    logic [DIV_NUM_W-1:0] r_x, r_q, r_r;
    logic [DIV_NUM_W-1:0] q_add;

    always_comb begin
        case (r_cnt)
            3'd0:    q_add = r_q >> 4;
            3'd1:    q_add = r_q >> 8;
            3'd2:    q_add = r_q >> 16;
            default: q_add = r_q >> 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt != STEP_FIX) begin
                    r_cnt <= r_cnt + 3'd1;
                end else if (r_r < DIVISOR) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // estimate stays at or below the true quotient; step it up until the remainder fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_num;
            r_q <= (i_num >> 1) + (i_num >> 2);
            r_r <= '0;
        end else if (r_busy) begin
            if (r_cnt < STEP_SCALE) begin
                r_q <= r_q + q_add;
            end else if (r_cnt == STEP_SCALE) begin
                r_q <= r_q >> 3;
            end else if (r_cnt == STEP_REM) begin
                r_r <= r_x - (r_q << 3) - (r_q << 1);
            end else if (r_r >= DIVISOR) begin
                r_q <= r_q + DIV_NUM_W'(1);
                r_r <= r_r - DIVISOR;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

@@ design/aaw_controller.sv @@
// Sequencer of the anti-replay window block: steps one item through the datapath.
// Depends on aaw_pkg.
module aaw_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  aaw_pkg::t_dp_sts i_sts,
    output aaw_pkg::t_dp_cmd o_cmd
);
    import aaw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_READ, S_EVAL, S_AVG, S_WSTART, S_WIN, S_SEQ, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.src_ge) o_cmd.mod_sub = 1'b1;
                else n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.enable) begin
                    n_state = S_DONE;
                end else if (i_sts.upd_avg) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_AVG;
                    n_state         = S_AVG;
                end else begin
                    n_state = S_WSTART;
                end
            end
            S_AVG: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_take = 1'b1;
                    n_state        = S_WSTART;
                end
            end
            S_WSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_WIN;
                n_state         = S_WIN;
            end
            S_WIN: begin
                o_cmd.div_sel = DIV_WIN;
                if (i_sts.div_done) begin
                    o_cmd.win_take = 1'b1;
                    n_state        = S_SEQ;
                end
            end
            S_SEQ: begin
                o_cmd.seq_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/aaw_datapath.sv @@
// Datapath of the anti-replay window block: config, per-source store, divider, result.
// Depends on aaw_pkg, aaw_divider and aaw_div10.
module aaw_datapath #(
    parameter int NUM_SOURCES = aaw_pkg::NUM_SOURCES_DEF,
    parameter int WINDOW_BITS = aaw_pkg::WINDOW_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aaw_pkg::t_dp_cmd               i_cmd,
    output aaw_pkg::t_dp_sts               o_sts,
    input  logic                           i_cfg_we,
    input  logic [aaw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aaw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [aaw_pkg::SRC_W-1:0]      i_source_id,
    input  logic [aaw_pkg::SEQ_W-1:0]      i_sequence_req,
    input  logic [aaw_pkg::ARR_W-1:0]      i_arrival_us,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_fresh_ok,
    output logic [aaw_pkg::WMSG_W-1:0]     o_window_msgs
);
    import aaw_pkg::*;

    localparam int IW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SW  = (IW > SRC_W) ? IW : SRC_W;
    localparam int SHW = $clog2(WINDOW_BITS);

    logic                   r_en;
    logic [SEQ_W-1:0]       r_wt;
    logic [SW-1:0]          r_src;
    logic [SEQ_W-1:0]       r_seq;
    logic [ARR_W-1:0]       r_now;

    logic [SEQ_W-1:0]       mem_hi   [NUM_SOURCES];
    logic [WINDOW_BITS-1:0] mem_bm   [NUM_SOURCES];
    logic [ARR_W-1:0]       mem_last [NUM_SOURCES];
    logic [AVG_W-1:0]       mem_avg  [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_vld;

    logic [SEQ_W-1:0]       r_rd_hi;
    logic [WINDOW_BITS-1:0] r_rd_bm;
    logic [ARR_W-1:0]       r_rd_last;
    logic [AVG_W-1:0]       r_rd_avg;
    logic                   r_rd_vld;

    logic [SEQ_W-1:0]       r_hi;
    logic [WINDOW_BITS-1:0] r_bm;
    logic [AVG_W-1:0]       r_avg;
    logic [WMSG_W-1:0]      r_w;
    logic                   r_ok;

    logic                   r_out_valid, r_fresh;
    logic [WMSG_W-1:0]      r_wout;

    logic [IW-1:0]          idx;
    logic [SEQ_W-1:0]       cur_hi;
    logic [WINDOW_BITS-1:0] cur_bm;
    logic [ARR_W-1:0]       cur_last, gap;
    logic [AVG_W-1:0]       cur_avg, win_den;
    logic [DIV_NUM_W-1:0]   avg_num, win_num, div_quo, avg_quo;
    logic                   win_start, avg_start, win_done, avg_done;
    logic [WMSG_W-1:0]      w_clamp;
    logic [SEQ_W-1:0]       shift, delta;
    logic [WINDOW_BITS-1:0] n_bm;
    logic [SEQ_W-1:0]       n_hi;
    logic                   n_ok;

    always_comb begin
        idx      = r_src[IW-1:0];
        cur_hi   = r_rd_vld ? r_rd_hi   : '0;
        cur_bm   = r_rd_vld ? r_rd_bm   : '0;
        cur_last = r_rd_vld ? r_rd_last : '0;
        cur_avg  = r_rd_vld ? r_rd_avg  : AVG_RESET;
        gap      = r_now - cur_last;
        avg_num  = ({8'd0, cur_avg} << 3) + {8'd0, cur_avg} + {8'd0, gap, 8'd0}
                 + DIV_NUM_W'(5);
        win_den  = (r_avg == '0) ? AVG_W'(1) : r_avg;
        win_num  = {24'd0, r_wt, 8'd0} + {8'd0, win_den} - DIV_NUM_W'(1);
        win_start = i_cmd.div_start && (i_cmd.div_sel == DIV_WIN);
        avg_start = i_cmd.div_start && (i_cmd.div_sel == DIV_AVG);

        if (div_quo == '0) w_clamp = WMSG_W'(1);
        else if (div_quo > DIV_NUM_W'(WINDOW_BITS)) w_clamp = WMSG_W'(WINDOW_BITS);
        else w_clamp = div_quo[WMSG_W-1:0];

        shift = r_seq - r_hi;
        delta = r_hi - r_seq;
        n_bm  = r_bm;
        n_hi  = r_hi;
        n_ok  = 1'b1;
        if (r_seq > r_hi) begin
            if (shift >= SEQ_W'(WINDOW_BITS)) n_bm = '0;
            else n_bm = r_bm << shift[SHW-1:0];
            n_bm[0] = 1'b1;
            n_hi    = r_seq;
        end else if (delta >= SEQ_W'(r_w)) begin
            n_ok = 1'b0;
        end else if (r_bm[delta[SHW-1:0]]) begin
            n_ok = 1'b0;
        end else begin
            n_bm[delta[SHW-1:0]] = 1'b1;
        end

        o_sts.src_ge   = (32'(r_src) >= 32'(NUM_SOURCES));
        o_sts.enable   = r_en;
        o_sts.upd_avg  = r_rd_vld && (r_now > cur_last);
        o_sts.div_done = win_done || avg_done;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    aaw_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (win_start),
        .i_num   (win_num),
        .i_den   (win_den),
        .o_done  (win_done),
        .o_quo   (div_quo)
    );

    aaw_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (avg_start),
        .i_num   (avg_num),
        .o_done  (avg_done),
        .o_quo   (avg_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= EN_RESET;
            r_wt        <= WT_RESET;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: r_en <= i_cfg_data[0];
                    CFG_WINDOW: r_wt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.rd) r_rd_vld <= r_vld[idx];
            if (i_cmd.seq_wr) r_vld[idx] <= 1'b1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_hi   <= mem_hi[idx];
            r_rd_bm   <= mem_bm[idx];
            r_rd_last <= mem_last[idx];
            r_rd_avg  <= mem_avg[idx];
        end
        if (i_cmd.seq_wr) begin
            mem_hi[idx]   <= n_hi;
            mem_bm[idx]   <= n_bm;
            mem_last[idx] <= r_now;
            mem_avg[idx]  <= r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src <= SW'(i_source_id);
            r_seq <= i_sequence_req;
            r_now <= i_arrival_us;
        end else if (i_cmd.mod_sub) begin
            r_src <= r_src - SW'(NUM_SOURCES);
        end
        if (i_cmd.eval) begin
            r_hi  <= cur_hi;
            r_bm  <= cur_bm;
            r_avg <= cur_avg;
            r_ok  <= 1'b1;
            r_w   <= '0;
        end
        if (i_cmd.avg_take) r_avg <= avg_quo[AVG_W-1:0];
        if (i_cmd.win_take) r_w <= w_clamp;
        if (i_cmd.seq_wr) r_ok <= n_ok;
        if (i_cmd.out_load) begin
            r_fresh <= r_ok;
            r_wout  <= r_w;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fresh_ok    = r_fresh;
    assign o_window_msgs = r_wout;

endmodule

@@ design/adaptive_antireplay_window.sv @@
// Top level of the adaptive anti-replay window block.
// Depends on aaw_pkg, aaw_controller and aaw_datapath.
//
// Input channel: i_in_valid / o_in_stall carries source, sequence and arrival
// time. Output channel: o_out_valid / i_out_stall carries fresh_ok and the
// window size used. One result per item, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 check enable, 1 window time in microseconds). The user must write it
// only while idle; the block itself does not enforce this. The window size
// comes from a 64-step bit-serial divider. An average gap update first
// divides by ten with a shift-and-add estimate and correction steps. A
// disabled check skips both dividers. With fewer than 256 sources the source
// number is reduced by one subtraction per cycle.
// One item is in work at a time; the next is taken while a result waits.
// Reset: synchronous, active low; all sources return to their initial state
// through per-entry valid bits, so no clearing pass is needed.
// Stall: a result held by i_out_stall stays on the outputs; a finished item
// waits for the output register before the block goes idle.
module adaptive_antireplay_window #(
    parameter int NUM_SOURCES = aaw_pkg::NUM_SOURCES_DEF,
    parameter int WINDOW_BITS = aaw_pkg::WINDOW_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aaw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aaw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [aaw_pkg::SRC_W-1:0]      i_source_id,
    input  logic [aaw_pkg::SEQ_W-1:0]      i_sequence_req,
    input  logic [aaw_pkg::ARR_W-1:0]      i_arrival_us,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_fresh_ok,
    output logic [aaw_pkg::WMSG_W-1:0]     o_window_msgs
);
    import aaw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    aaw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    aaw_datapath #(
        .NUM_SOURCES (NUM_SOURCES),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_source_id    (i_source_id),
        .i_sequence_req (i_sequence_req),
        .i_arrival_us   (i_arrival_us),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_fresh_ok     (o_fresh_ok),
        .o_window_msgs  (o_window_msgs)
    );

endmodule

@@ design/aaw_checker.sv @@
// Port-level assertions of the anti-replay window block, bound to the top level.
// Depends on aaw_pkg and adaptive_antireplay_window_macros.svh.
`include "adaptive_antireplay_window_macros.svh"
module aaw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_fresh_ok,
    input logic [aaw_pkg::WMSG_W-1:0]     o_window_msgs
);
    import aaw_pkg::*;

    `AAW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_fresh_ok) && $stable(o_window_msgs),
        "stalled result changed")
    `AAW_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall,
        "second item taken while one is in work")
    `AAW_ASSERT_SAME(a_window_range, o_out_valid, o_window_msgs <= 7'd64,
        "window size above limit")
    `AAW_ASSERT_SAME(a_disabled_pass, o_out_valid && (o_window_msgs == 7'd0), o_fresh_ok,
        "item rejected with the check disabled")
    `AAW_ASSERT_SAME(a_reset_clear, $past(!i_rst_n), !o_out_valid,
        "result shown straight after reset")

endmodule

bind adaptive_antireplay_window aaw_checker u_aaw_checker (.*);

@@ tb/sv/adaptive_antireplay_window_tb.sv @@
// Self-checking testbench for the adaptive anti-replay window block.
// Depends on aaw_pkg and adaptive_antireplay_window; a scoreboard class predicts each result.

class replay_scoreboard;
    bit           check_on;
    bit [31:0]    win_time;
    bit [31:0]    top_seq  [256];
    bit [63:0]    seen_map [256];
    bit [47:0]    prev_arr [256];
    bit           arr_valid[256];
    bit [55:0]    gap_avg  [256];
    bit           want_ok[$];
    bit [6:0]     want_win[$];
    int           errors;
    int           checked;

    function void clear_state();
        check_on = 1'b1;
        win_time = 32'd1000000;
        for (int i = 0; i < 256; i++) begin
            top_seq[i]   = '0;
            seen_map[i]  = '0;
            prev_arr[i]  = '0;
            arr_valid[i] = 1'b0;
            gap_avg[i]   = 56'd256000000;
        end
    endfunction

    function void queue_result(bit ok, bit [6:0] wmsg);
        want_ok  = {want_ok, ok};
        want_win = {want_win, wmsg};
    endfunction

    function void note_item(bit [7:0] src, bit [31:0] seq, bit [47:0] arr);
        bit [63:0] num, den, acc, wide, quo;
        bit [31:0] seq_off;
        bit [6:0]  wmsg;
        bit        ok;
        ok = 1'b1;
        if (!check_on) begin
            queue_result(1'b1, 7'd0);
            return;
        end
        if (arr_valid[src] && arr > prev_arr[src]) begin
            wide = 64'd9 * gap_avg[src] + ({16'd0, arr - prev_arr[src]} << 8) + 64'd5;
            quo  = wide / 64'd10;
            gap_avg[src] = quo[55:0];
        end
        prev_arr[src]  = arr;
        arr_valid[src] = 1'b1;
        num = {24'd0, win_time, 8'd0};
        den = (gap_avg[src] == 0) ? 64'd1 : {8'd0, gap_avg[src]};
        acc = (num + den - 64'd1) / den;
        if (acc < 64'd1) acc = 64'd1;
        if (acc > 64'd64) acc = 64'd64;
        wmsg = acc[6:0];
        if (seq > top_seq[src]) begin
            seq_off = seq - top_seq[src];
            if (seq_off >= 32'd64) seen_map[src] = '0;
            else seen_map[src] = seen_map[src] << seq_off;
            seen_map[src] |= 64'd1;
            top_seq[src] = seq;
        end else begin
            seq_off = top_seq[src] - seq;
            if (seq_off >= {25'd0, wmsg}) ok = 1'b0;
            else if (seen_map[src][seq_off[5:0]]) ok = 1'b0;
            else seen_map[src][seq_off[5:0]] = 1'b1;
        end
        queue_result(ok, wmsg);
    endfunction

    function void check_result(bit ok, bit [6:0] wmsg);
        bit       e_ok;
        bit [6:0] e_win;
        if (want_ok.size() == 0) begin
            $display("%0t: unexpected result fresh_ok=%0d window_msgs=%0d", $time, ok, wmsg);
            errors++;
            return;
        end
        e_ok  = want_ok.pop_front();
        e_win = want_win.pop_front();
        checked++;
        if (ok !== e_ok) begin
            $display("%0t: fresh_ok expected %0d actual %0d", $time, e_ok, ok);
            errors++;
        end
        if (wmsg !== e_win) begin
            $display("%0t: window_msgs expected %0d actual %0d", $time, e_win, wmsg);
            errors++;
        end
    endfunction
endclass

module adaptive_antireplay_window_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aaw_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SRC_W-1:0]      i_source_id = '0;
    logic [SEQ_W-1:0]      i_sequence_req = '0;
    logic [ARR_W-1:0]      i_arrival_us = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_fresh_ok;
    logic [WMSG_W-1:0]     o_window_msgs;

    replay_scoreboard sb;
    int        snd_pct;
    int        rcv_pct;
    bit        hold_req;
    int        hold_cnt;
    int        cycles;
    int        sent;
    bit [47:0] clk_us[256];

    adaptive_antireplay_window u_top (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt <= 400;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_fresh_ok, o_window_msgs);
    end

    task automatic send_item(bit [7:0] src, bit [31:0] seq, bit [47:0] arr);
        while ($urandom_range(99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_source_id    <= src;
        i_sequence_req <= seq;
        i_arrival_us   <= arr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(src, seq, arr);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.want_ok.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENABLE) sb.check_on = data[0];
        else sb.win_time = data;
    endtask

    task automatic random_item();
        bit [7:0]  src;
        bit [31:0] seq;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_item(8'($urandom_range(255)), $urandom, 48'({$urandom, $urandom}));
            return;
        end
        src = (pick < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 3) clk_us[src] = clk_us[src] - $urandom_range(5000);
        else if (pick < 5) clk_us[src] = clk_us[src] + (48'd1 << $urandom_range(20, 40));
        else clk_us[src] = clk_us[src] + $urandom_range(2, 3000);
        pick = $urandom_range(99);
        if (pick < 5) seq = sb.top_seq[src] + $urandom_range(64, 500);
        else seq = sb.top_seq[src] + $urandom_range(70) - $urandom_range(70);
        send_item(src, seq, clk_us[src]);
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        snd_pct = 0;
        rcv_pct = 0;
        for (int i = 0; i < 256; i++) clk_us[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(8'd0, 32'd0, 48'd0);
        send_item(8'd0, 32'd0, 48'd100);
        send_item(8'd0, 32'd5, 48'd200);
        send_item(8'd0, 32'd3, 48'd250);
        send_item(8'd0, 32'd4, 48'd150);
        send_item(8'd0, 32'd200, 48'd160);
        send_item(8'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(8'd255, 32'hFFFF_FFFF, 48'd0);
        send_item(8'd255, 32'hFFFF_FFFE, 48'd1);
        send_item(8'd170, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        send_item(8'd85, 32'h5555_5555, 48'h5555_5555_5555);
        cfg_write(CFG_WINDOW, 32'd0);
        send_item(8'd1, 32'd10, 48'd10);
        send_item(8'd1, 32'd10, 48'd20);
        cfg_write(CFG_WINDOW, 32'hFFFF_FFFF);
        send_item(8'd1, 32'd100, 48'd30);
        send_item(8'd1, 32'd37, 48'd40);
        send_item(8'd1, 32'd36, 48'd50);
        send_item(8'd1, 32'd37, 48'd60);
        cfg_write(CFG_ENABLE, 32'hFFFF_FFFE);
        send_item(8'd1, 32'd0, 48'd70);
        send_item(8'd2, 32'd9, 48'd80);
        cfg_write(CFG_ENABLE, 32'h0000_0001);

        cfg_write(CFG_WINDOW, 32'd2000);
        snd_pct = 34;
        rcv_pct = 66;
        repeat (640) random_item();
        cfg_write(CFG_WINDOW, 32'd100000);
        snd_pct = 66;
        rcv_pct = 34;
        repeat (640) random_item();
        cfg_write(CFG_WINDOW, 32'd20000);
        snd_pct = 0;
        rcv_pct = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        repeat (640) random_item();
        drain();

        $display("Ran %0d items over %0d results, incl. disabled check, zero and full window,",
                 sent, sb.checked);
        $display("time going backwards, large jumps and a long output hold-off.");
        if (sb.errors == 0 && sb.want_ok.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ adaptive_antireplay_window.f @@
+incdir+design
design/aaw_pkg.sv
design/aaw_divider.sv
design/aaw_controller.sv
design/aaw_datapath.sv
design/adaptive_antireplay_window.sv
design/aaw_checker.sv
tb/sv/adaptive_antireplay_window_tb.sv
